[rtl/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation block.
// Used by mexp_ctrl, mexp_datapath and modular_exponentiation; no dependencies.
package mexp_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned EXP_W = 63;

    // Bit counters: one count per operand bit plus start and commit cycles
    localparam int unsigned STEP_CNT_W = $clog2(WORD_W + 2);
    localparam int unsigned EXP_CNT_W = $clog2(EXP_W);

    localparam logic [WORD_W-1:0] MODULUS_RESET = WORD_W'(32'd1000000007);

    typedef enum logic [1:0] {
        OP_REDUCE = 2'd0,
        OP_SQUARE = 2'd1,
        OP_MULT   = 2'd2
    } op_t;

    typedef struct packed {
        logic load;
        logic op_start;
        logic op_step;
        logic op_write;
        op_t  op_sel;
        logic exp_shift;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic exp_msb;
        logic mod_small;
    } status_t;

endpackage

[rtl/mexp_datapath.sv]
// Datapath: modulus register, operand registers and the shared shift-add
// modular multiplier/reducer. Depends on mexp_pkg; driven by mexp_ctrl.
module mexp_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           modulus_we,
    input  logic [mexp_pkg::WORD_W-1:0]    modulus_wdata,
    input  logic [mexp_pkg::WORD_W-1:0]    base_value,
    input  logic [mexp_pkg::EXP_W-1:0]     exponent,
    input  mexp_pkg::cmd_t                 cmd,
    output mexp_pkg::status_t              status,
    output logic [mexp_pkg::WORD_W-1:0]    result
);

    localparam int unsigned W = mexp_pkg::WORD_W;

    logic [W-1:0]                  mod_reg;
    logic [W-1:0]                  base_reg;
    logic [mexp_pkg::EXP_W-1:0]    exp_reg;
    logic [W-1:0]                  acc_reg;
    logic [W-1:0]                  r_reg;
    logic [W-1:0]                  x_reg;
    logic [W-1:0]                  y_reg;
    logic [W-1:0]                  result_reg;

    logic [W:0]   mod_ext;
    logic         is_reduce;
    logic         in_bit;
    logic [W:0]   dbl;
    logic [W-1:0] dbl_red;
    logic [W:0]   sum;
    logic [W-1:0] r_next;

    assign mod_ext   = {1'b0, mod_reg};
    assign is_reduce = (cmd.op_sel == mexp_pkg::OP_REDUCE);
    // Reduction shifts in the raw base bits; multiplication adds x per y bit
    assign in_bit    = is_reduce & y_reg[W-1];
    assign dbl       = {r_reg, in_bit};
    assign dbl_red   = (dbl >= mod_ext) ? W'(dbl - mod_ext) : dbl[W-1:0];
    assign sum       = {1'b0, dbl_red} + ((!is_reduce && y_reg[W-1]) ? {1'b0, x_reg} : '0);
    assign r_next    = (sum >= mod_ext) ? W'(sum - mod_ext) : sum[W-1:0];

    assign status.exp_msb   = exp_reg[mexp_pkg::EXP_W-1];
    assign status.mod_small = (mod_reg[W-1:1] == '0);
    assign result           = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= mexp_pkg::MODULUS_RESET;
        end
        else if (modulus_we)
        begin
            mod_reg <= modulus_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base_value;
            exp_reg  <= exponent;
            acc_reg  <= W'(1);
        end
        else
        begin
            if (cmd.exp_shift)
            begin
                exp_reg <= {exp_reg[mexp_pkg::EXP_W-2:0], 1'b0};
            end
            if (cmd.op_write)
            begin
                if (is_reduce)
                begin
                    base_reg <= r_reg;
                end
                else
                begin
                    acc_reg <= r_reg;
                end
            end
        end

        if (cmd.op_start)
        begin
            r_reg <= '0;
            case (cmd.op_sel)
                mexp_pkg::OP_REDUCE:
                begin
                    x_reg <= '0;
                    y_reg <= base_reg;
                end
                mexp_pkg::OP_SQUARE:
                begin
                    x_reg <= acc_reg;
                    y_reg <= acc_reg;
                end
                mexp_pkg::OP_MULT:
                begin
                    x_reg <= base_reg;
                    y_reg <= acc_reg;
                end
                default:
                begin
                    x_reg <= '0;
                    y_reg <= '0;
                end
            endcase
        end
        else if (cmd.op_step)
        begin
            r_reg <= r_next;
            y_reg <= {y_reg[W-2:0], 1'b0};
        end

        if (cmd.out_load)
        begin
            result_reg <= status.mod_small ? '0 : acc_reg;
        end
    end

endmodule

[rtl/mexp_ctrl.sv]
// Controller: sequences base reduction, then square and conditional multiply
// per exponent bit, and owns the handshakes. Depends on mexp_pkg.
module mexp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  mexp_pkg::status_t  status,
    output mexp_pkg::cmd_t     cmd
);

    localparam int unsigned SW = mexp_pkg::STEP_CNT_W;
    localparam int unsigned EW = mexp_pkg::EXP_CNT_W;
    localparam logic [SW-1:0] STEP_LAST = SW'(mexp_pkg::WORD_W + 1);
    localparam logic [EW-1:0] EXP_LAST  = EW'(mexp_pkg::EXP_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQUARE,
        S_MULT,
        S_FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [EW-1:0]   exp_cnt_reg, exp_cnt_next;
    logic            out_valid_reg, out_valid_next;

    logic in_beat;
    logic op_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign in_beat   = in_valid && in_ready;
    assign op_last   = (step_reg == STEP_LAST);

    always_comb
    begin
        cmd            = '0;
        cmd.op_sel     = mexp_pkg::OP_REDUCE;
        state_next     = state_reg;
        step_next      = step_reg;
        exp_cnt_next   = exp_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    cmd.load     = 1'b1;
                    step_next    = '0;
                    exp_cnt_next = '0;
                    state_next   = status.mod_small ? S_FINISH : S_REDUCE;
                end
            end
            S_REDUCE, S_SQUARE, S_MULT:
            begin
                cmd.op_sel = (state_reg == S_REDUCE) ? mexp_pkg::OP_REDUCE :
                             (state_reg == S_SQUARE) ? mexp_pkg::OP_SQUARE :
                                                       mexp_pkg::OP_MULT;
                cmd.op_start = (step_reg == '0);
                cmd.op_step  = !cmd.op_start && !op_last;
                cmd.op_write = op_last;
                step_next    = op_last ? '0 : step_reg + SW'(1);
                if (op_last)
                begin
                    if (state_reg == S_REDUCE)
                    begin
                        state_next = S_SQUARE;
                    end
                    else if (state_reg == S_SQUARE && status.exp_msb)
                    begin
                        state_next = S_MULT;
                    end
                    else
                    begin
                        // advance to the next exponent bit
                        cmd.exp_shift = 1'b1;
                        if (exp_cnt_reg == EXP_LAST)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            exp_cnt_next = exp_cnt_reg + EW'(1);
                            state_next   = S_SQUARE;
                        end
                    end
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            exp_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            exp_cnt_reg   <= exp_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not presented");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("input accepted twice back to back");

    a_exp_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQUARE || state_reg == S_MULT) |-> (exp_cnt_reg <= EXP_LAST))
        else $error("exponent bit counter out of range");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("step counter out of range");

endmodule

[rtl/modular_exponentiation.sv]
// Top level of the modular exponentiation block: controller plus datapath.
// Depends on mexp_pkg, mexp_ctrl and mexp_datapath.
//
// Computes base_value^exponent mod modulus by left-to-right square-and-multiply
// over all 63 exponent bits, with the base reduced first. One shared shift-add
// unit does every reduction and modular product, one operand bit per cycle; each
// operation runs as a start step, one step per operand bit (32 bits) and a commit
// step. A modulus of 0 or 1 skips the arithmetic: the controller goes straight to
// its finish state, which loads 0 into the output register. One item is in
// work at a time; a finished result waits in the output register while the
// next input beat is taken. Write modulus only while the block is idle.
module modular_exponentiation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          modulus_we,
    input  logic [mexp_pkg::WORD_W-1:0]   modulus_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mexp_pkg::WORD_W-1:0]   base_value,
    input  logic [mexp_pkg::EXP_W-1:0]    exponent,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mexp_pkg::WORD_W-1:0]   result
);

    mexp_pkg::cmd_t    cmd;
    mexp_pkg::status_t status;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mexp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .modulus_we    (modulus_we),
        .modulus_wdata (modulus_wdata),
        .base_value    (base_value),
        .exponent      (exponent),
        .cmd           (cmd),
        .status        (status),
        .result        (result)
    );

endmodule

[bench/mexp_checker.sv]
// Result checker for the modular exponentiation block: watches the modulus write port and both
// handshake channels, predicts every result and compares it with what the block returns.
// Depends on mexp_pkg.
module mexp_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          modulus_we,
    input  logic [mexp_pkg::WORD_W-1:0]   modulus_wdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [mexp_pkg::WORD_W-1:0]   base_value,
    input  logic [mexp_pkg::EXP_W-1:0]    exponent,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [mexp_pkg::WORD_W-1:0]   result,
    output int unsigned                   mismatch_count,
    output int unsigned                   powers_due
);

    logic [mexp_pkg::WORD_W-1:0] modulus_q;
    logic [mexp_pkg::WORD_W-1:0] expected_powers[$];

    // Left-to-right square-and-multiply over all exponent bits, reducing after each product.
    function automatic logic [mexp_pkg::WORD_W-1:0] power_mod(
        input logic [mexp_pkg::WORD_W-1:0] m,
        input logic [mexp_pkg::WORD_W-1:0] b,
        input logic [mexp_pkg::EXP_W-1:0]  e
    );
        logic [63:0] m_wide;
        logic [63:0] b_red;
        logic [63:0] acc;
        if (m == '0)
            return '0;
        m_wide = {32'd0, m};
        b_red = {32'd0, b} % m_wide;
        acc = 64'd1 % m_wide;
        for (int i = mexp_pkg::EXP_W - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % m_wide;
            if (e[i])
                acc = (acc * b_red) % m_wide;
        end
        return acc[mexp_pkg::WORD_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [mexp_pkg::WORD_W-1:0] oldest;
        if (!rst_n)
        begin
            modulus_q <= mexp_pkg::MODULUS_RESET;
            expected_powers.delete();
            mismatch_count <= 0;
            powers_due <= 0;
        end
        else
        begin
            // Check the result beat first so a beat never meets its own input beat.
            if (out_valid && out_ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("result beat with no expectation waiting: actual %0d", result);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    oldest = expected_powers.pop_front();
                    if (result !== oldest)
                    begin
                        $error("result mismatch: expected %0d, actual %0d", oldest, result);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_powers = {expected_powers,
                                   power_mod(modulus_q, base_value, exponent)};
            if (modulus_we)
                modulus_q <= modulus_wdata;
            powers_due <= expected_powers.size();
        end
    end

endmodule

[bench/tb_modular_exponentiation.sv]
// Testbench top for modular_exponentiation: clock, reset, operand and modulus stimulus,
// random stalls on the result side and the final verdict.
// Depends on mexp_pkg, modular_exponentiation and mexp_checker.
module tb_modular_exponentiation;

    localparam int          CLK_HALF         = 4;
    localparam longint      TIMEOUT_CYCLES   = 4_000_000;
    localparam int          RANDOM_PHASES    = 7;
    localparam int          ITEMS_PER_PHASE  = 17;
    localparam int          LONG_HOLD_BEAT   = 50;
    localparam int          LONG_HOLD_CYCLES = 12000;
    localparam int          DRAIN_CYCLES     = 40;

    localparam logic [mexp_pkg::EXP_W-1:0]  EXP_ALL_ONES = '1;
    localparam logic [mexp_pkg::WORD_W-1:0] WORD_ALL_ONES = '1;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          modulus_we = 1'b0;
    logic [mexp_pkg::WORD_W-1:0]   modulus_wdata = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [mexp_pkg::WORD_W-1:0]   base_value = '0;
    logic [mexp_pkg::EXP_W-1:0]    exponent = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [mexp_pkg::WORD_W-1:0]   result;

    int unsigned                   mismatch_count;
    int unsigned                   powers_due;
    logic [mexp_pkg::WORD_W-1:0]   cur_modulus = mexp_pkg::MODULUS_RESET;
    bit                            steady_sender = 1'b0;

    modular_exponentiation dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .modulus_we    (modulus_we),
        .modulus_wdata (modulus_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .base_value    (base_value),
        .exponent      (exponent),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result        (result)
    );

    mexp_checker power_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .modulus_we     (modulus_we),
        .modulus_wdata  (modulus_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .base_value     (base_value),
        .exponent       (exponent),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result         (result),
        .mismatch_count (mismatch_count),
        .powers_due     (powers_due)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int sender_gap();
        int pick;
        if (steady_sender)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 4);
        else if (pick < 97)
            return $urandom_range(5, 30);
        return $urandom_range(100, 400);
    endfunction

    function automatic int sink_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 8);
        return $urandom_range(50, 300);
    endfunction

    function automatic logic [mexp_pkg::WORD_W-1:0] pick_base(
        input logic [mexp_pkg::WORD_W-1:0] m
    );
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 1;
            2: return WORD_ALL_ONES;
            3: return m - 1;
            4: return m;
            5: return m + $urandom_range(1, 5);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [mexp_pkg::EXP_W-1:0] pick_exponent();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return {31'd0, $urandom_range(0, 3)};
            1: return EXP_ALL_ONES;
            2: return 63'd1 << $urandom_range(0, mexp_pkg::EXP_W - 1);
            3: return {31'd0, $urandom_range(0, 1000)};
            default: return raw[mexp_pkg::EXP_W-1:0];
        endcase
    endfunction

    function automatic logic [mexp_pkg::WORD_W-1:0] pick_modulus();
        logic [mexp_pkg::WORD_W-1:0] m;
        case ($urandom_range(0, 7))
            0: return 2;
            1: return WORD_ALL_ONES;
            2: return $urandom_range(2, 64);
            3: return 32'h8000_0000 | $urandom;
            4: return mexp_pkg::MODULUS_RESET;
            default:
            begin
                m = $urandom;
                if (m < 2)
                    m = 2;
                return m;
            end
        endcase
    endfunction

    // Hold valid and payload until the beat is taken; keep valid high when no gap follows.
    task automatic offer_operands(
        input logic [mexp_pkg::WORD_W-1:0] b,
        input logic [mexp_pkg::EXP_W-1:0]  e
    );
        int gap;
        in_valid <= 1'b1;
        base_value <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (!in_ready);
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (powers_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [mexp_pkg::WORD_W-1:0] value);
        wait_results_drained();
        modulus_we <= 1'b1;
        modulus_wdata <= value;
        @(posedge clk);
        modulus_we <= 1'b0;
        cur_modulus = value;
    endtask

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset modulus: zero exponent, exponent of one, base at and above the modulus.
        offer_operands(0, 0);
        offer_operands(0, 5);
        offer_operands(5, 1);
        offer_operands(mexp_pkg::MODULUS_RESET, 3);
        offer_operands(mexp_pkg::MODULUS_RESET + 1, 1);
        offer_operands(WORD_ALL_ONES, 1);
        offer_operands(WORD_ALL_ONES, EXP_ALL_ONES);
        offer_operands(2, 63'd1 << (mexp_pkg::EXP_W - 1));
        offer_operands(123456789, 0);

        write_modulus(2);
        offer_operands(3, 0);
        offer_operands(3, 1);
        offer_operands(WORD_ALL_ONES, EXP_ALL_ONES);
        offer_operands(2, 5);

        write_modulus(WORD_ALL_ONES);
        offer_operands(WORD_ALL_ONES, 1);
        offer_operands(WORD_ALL_ONES - 1, 2);
        offer_operands(WORD_ALL_ONES - 1, EXP_ALL_ONES);
        offer_operands(0, 0);
        offer_operands(12345, pick_exponent());

        // Degenerate moduli: every result is zero.
        write_modulus(1);
        offer_operands(5, 0);
        offer_operands(7, 3);

        write_modulus(0);
        offer_operands(5, 0);
        offer_operands(WORD_ALL_ONES, EXP_ALL_ONES);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_modulus(pick_modulus());
            steady_sender = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer_operands(pick_base(cur_modulus), pick_exponent());
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : result_sink
        int  beats_taken;
        int  stall;
        bit  long_hold_done;
        bit  steady;
        beats_taken = 0;
        long_hold_done = 1'b0;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            stall = 0;
            if (out_valid && out_ready)
            begin
                beats_taken++;
                if (beats_taken % 16 == 0)
                    steady = ($urandom_range(0, 2) == 0);
                if (!steady)
                    stall = sink_gap();
            end
            else if (!steady && $urandom_range(0, 63) == 0)
                stall = $urandom_range(1, 40);
            // Hold off long enough for the block to fill up and stall its input.
            if (beats_taken == LONG_HOLD_BEAT && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                stall = LONG_HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

endmodule
